FILE: hdl/chunked_body_decoder_defines.svh
// ----------------------------------------------------------------------------
// Chunked body decoder assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BODY_DECODER_DEFINES_SVH
`define CHUNKED_BODY_DECODER_DEFINES_SVH

// same-cycle implication
`define CBD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CBD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Widths, character codes, stage and error codes, state and result types.
// ----------------------------------------------------------------------------
package cbd_pkg;

   localparam int MAX_HEX_DIGITS = 15;
   localparam int SIZE_W         = 4 * MAX_HEX_DIGITS;
   localparam int DCNT_W         = $clog2(MAX_HEX_DIGITS + 1);
   localparam int RAW_W          = 32;
   localparam int BYTE_W         = 8;
   localparam int STATUS_W       = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;

   localparam logic [RAW_W-1:0] MAX_RAW_RESET = 32'd65536;

   // register index is the word address bit
   localparam logic CSR_IDX_MAX_RAW = 1'b0;

   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;

   typedef enum logic [2:0] {
      ST_SIZE,
      ST_EXT,
      ST_DATA,
      ST_CRLF,
      ST_TRAIL
   } stage_type;

   typedef enum logic [STATUS_W-1:0] {
      ERR_NONE,
      ERR_SIZE,
      ERR_CRLF,
      ERR_LIMIT,
      ERR_CLOSED
   } err_type;

   typedef struct packed {
      stage_type          stage;
      logic [SIZE_W-1:0]  size_accum;
      logic [DCNT_W-1:0]  digit_count;
      logic [SIZE_W-1:0]  chunk_left;
      logic               saw_cr;
      logic               line_has_text;
      logic [RAW_W-1:0]   raw_count;
      err_type            sticky_error;
   } state_type;

   typedef struct packed {
      logic               body_valid;
      logic [BYTE_W-1:0]  body_byte;
      logic               done_res;
      err_type            status;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   localparam state_type STATE_RESET = '{
      stage:         ST_SIZE,
      size_accum:    '0,
      digit_count:   '0,
      chunk_left:    '0,
      saw_cr:        1'b0,
      line_has_text: 1'b0,
      raw_count:     '0,
      sticky_error:  ERR_NONE
   };

   function automatic hex_type hex_digit(input logic [BYTE_W-1:0] c);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.val = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

FILE: hdl/cbd_req_if.sv
// ----------------------------------------------------------------------------
// Chunked body decoder request channel
// One raw byte or a connection-close event per transfer.
// ----------------------------------------------------------------------------
interface cbd_req_if import cbd_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              conn_closed;

   modport source (output valid, output in_byte, output conn_closed, input ready);
   modport sink   (input valid, input in_byte, input conn_closed, output ready);

endinterface

FILE: hdl/cbd_rsp_if.sv
// ----------------------------------------------------------------------------
// Chunked body decoder response channel
// One decoded result per transfer.
// ----------------------------------------------------------------------------
interface cbd_rsp_if import cbd_pkg::*; ();

   logic                valid;
   logic                ready;
   logic                body_valid;
   logic [BYTE_W-1:0]   body_byte;
   logic                done_res;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output body_valid, output body_byte,
                   output done_res, output status, input ready);
   modport sink   (input valid, input body_valid, input body_byte,
                   input done_res, input status, output ready);

endinterface

FILE: hdl/cbd_csr.sv
// ----------------------------------------------------------------------------
// Chunked body decoder register block
// APB-style access to the raw byte limit register.
// ----------------------------------------------------------------------------
module cbd_csr import cbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [RAW_W-1:0]      max_raw
);

   logic [RAW_W-1:0] max_raw_ff;
   logic [RAW_W-1:0] max_raw_in;
   logic             wr_hit;

   assign wr_hit = psel && penable && pwrite && (paddr[2] == CSR_IDX_MAX_RAW);

   always_comb begin
      max_raw_in = max_raw_ff;
      if (wr_hit) begin
         max_raw_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_raw_ff <= MAX_RAW_RESET;
      end else begin
         max_raw_ff <= max_raw_in;
      end
   end

   assign prdata  = (paddr[2] == CSR_IDX_MAX_RAW) ? max_raw_ff : '0;
   assign pready  = 1'b1;
   assign max_raw = max_raw_ff;

endmodule

FILE: hdl/cbd_step.sv
// ----------------------------------------------------------------------------
// Chunked body decoder step logic
// Next state and result for one registered byte or close event.
// ----------------------------------------------------------------------------
module cbd_step import cbd_pkg::*; (
   input  state_type         cur,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              conn_closed,
   input  logic [RAW_W-1:0]  max_raw,
   output state_type         nxt,
   output result_type        res
);

   hex_type           hex;
   logic [RAW_W-1:0]  raw_inc;
   logic [SIZE_W-1:0] chunk_dec;
   logic [DCNT_W:0]   dcnt_inc;
   logic              end_line;
   logic              restart;

   assign hex       = hex_digit(in_byte);
   assign raw_inc   = (cur.raw_count == '1) ? cur.raw_count : cur.raw_count + 1'b1;
   assign chunk_dec = cur.chunk_left - 1'b1;
   assign dcnt_inc  = {1'b0, cur.digit_count} + 1'b1;

   always_comb begin
      nxt            = cur;
      res.body_valid = 1'b0;
      res.body_byte  = '0;
      res.done_res   = 1'b0;
      end_line       = 1'b0;
      restart        = 1'b0;

      if (cur.sticky_error == ERR_NONE) begin
         if (conn_closed) begin
            nxt.sticky_error = ERR_CLOSED;
         end else begin
            nxt.raw_count = raw_inc;
            unique case (cur.stage)
               ST_SIZE: begin
                  if (cur.saw_cr) begin
                     if (in_byte == CHAR_LF) end_line = 1'b1;
                     else nxt.sticky_error = ERR_SIZE;
                  end else if (hex.ok) begin
                     if (dcnt_inc > (DCNT_W+1)'(MAX_HEX_DIGITS)) begin
                        nxt.sticky_error = ERR_SIZE;
                     end else begin
                        nxt.digit_count = dcnt_inc[DCNT_W-1:0];
                        nxt.size_accum  = {cur.size_accum[SIZE_W-5:0], hex.val};
                     end
                  end else if (cur.digit_count == '0) begin
                     nxt.sticky_error = ERR_SIZE;
                  end else if (in_byte == CHAR_CR) begin
                     nxt.saw_cr = 1'b1;
                  end else if (in_byte == CHAR_SEMI || in_byte == CHAR_SPACE ||
                               in_byte == CHAR_TAB) begin
                     nxt.stage = ST_EXT;
                  end else begin
                     nxt.sticky_error = ERR_SIZE;
                  end
               end
               ST_EXT: begin
                  if (cur.saw_cr && in_byte == CHAR_LF) end_line = 1'b1;
                  else nxt.saw_cr = (in_byte == CHAR_CR);
               end
               ST_DATA: begin
                  nxt.chunk_left = chunk_dec;
                  if (chunk_dec != '0 && raw_inc >= max_raw) begin
                     nxt.sticky_error = ERR_LIMIT;
                  end else begin
                     res.body_valid = 1'b1;
                     res.body_byte  = in_byte;
                     if (chunk_dec == '0) begin
                        nxt.stage  = ST_CRLF;
                        nxt.saw_cr = 1'b0;
                     end
                  end
               end
               ST_CRLF: begin
                  if (!cur.saw_cr) begin
                     if (in_byte == CHAR_CR) nxt.saw_cr = 1'b1;
                     else nxt.sticky_error = ERR_CRLF;
                  end else if (in_byte == CHAR_LF) begin
                     nxt.stage       = ST_SIZE;
                     nxt.saw_cr      = 1'b0;
                     nxt.size_accum  = '0;
                     nxt.digit_count = '0;
                  end else begin
                     nxt.sticky_error = ERR_CRLF;
                  end
               end
               ST_TRAIL: begin
                  if (cur.saw_cr && in_byte == CHAR_LF) begin
                     if (!cur.line_has_text) begin
                        res.done_res = 1'b1;
                        restart      = 1'b1;
                     end else begin
                        nxt.line_has_text = 1'b0;
                        nxt.saw_cr        = 1'b0;
                     end
                  end else begin
                     // a lone CR inside a trailer line is line text
                     if (cur.saw_cr) nxt.line_has_text = 1'b1;
                     if (in_byte == CHAR_CR) begin
                        nxt.saw_cr = 1'b1;
                     end else begin
                        nxt.line_has_text = 1'b1;
                        nxt.saw_cr        = 1'b0;
                     end
                  end
               end
               default: begin
                  nxt = cur;
               end
            endcase

            // size line done: enter data, or trailers on a zero-size chunk
            if (end_line) begin
               nxt.saw_cr        = 1'b0;
               nxt.line_has_text = 1'b0;
               if (cur.size_accum == '0) begin
                  nxt.stage = ST_TRAIL;
               end else begin
                  nxt.chunk_left = cur.size_accum;
                  nxt.stage      = ST_DATA;
               end
               nxt.size_accum  = '0;
               nxt.digit_count = '0;
            end

            if (restart) begin
               nxt = STATE_RESET;
            end
         end
      end

      res.status = nxt.sticky_error;
   end

endmodule

FILE: hdl/chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// Chunked body decoder
// Decodes an HTTP/1.1 chunked body one raw byte per transfer.
//
//   channel   direction  transfers
//   req_chan  in         one raw byte or a connection-close event
//   rsp_chan  out        one result: body byte, done mark, status
//   csr_*     in/out     APB-style access to the raw byte limit
//
// One byte per cycle while rsp_chan is not stalled; each request passes
// the input register, then the result register, on its way to a result.
// The step logic reads the per-body state register and writes it back in
// the same cycle, so each byte sees the state left by the one before.
// Synchronous reset clears valid flags and state at once; no clearing pass.
// A stalled response holds the result register and, behind it, the input
// register; req_chan stays ready while either register can move.
// ----------------------------------------------------------------------------
`include "chunked_body_decoder_defines.svh"

module chunked_body_decoder import cbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cbd_req_if.sink               req_chan,
   cbd_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [RAW_W-1:0]  max_raw;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_closed_ff;

   state_type         st_ff;
   state_type         st_in;
   state_type         st_nxt;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   result_type        rsp_ff;
   result_type        rsp_nxt;

   logic              req_take;
   logic              advance;

   cbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .max_raw (max_raw)
   );

   cbd_step u_step (
      .cur         (st_ff),
      .in_byte     (in_byte_ff),
      .conn_closed (in_closed_ff),
      .max_raw     (max_raw),
      .nxt         (st_nxt),
      .res         (rsp_nxt)
   );

   // move the held byte into the result register when it has room
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      st_in        = st_ff;
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (advance) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         st_in        = st_nxt;
      end
      if (req_take) in_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff   <= req_chan.in_byte;
         in_closed_ff <= req_chan.conn_closed;
      end
      if (advance) begin
         rsp_ff <= rsp_nxt;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.body_valid = rsp_ff.body_valid;
   assign rsp_chan.body_byte  = rsp_ff.body_byte;
   assign rsp_chan.done_res   = rsp_ff.done_res;
   assign rsp_chan.status     = rsp_ff.status;

   `CBD_ASSERT_NXT(a_sticky_hold, st_ff.sticky_error != ERR_NONE, $stable(st_ff.sticky_error), "sticky error changed")
   `CBD_ASSERT_IMP(a_body_ok, rsp_valid_ff && rsp_ff.body_valid, rsp_ff.status == ERR_NONE, "body byte carried with an error status")
   `CBD_ASSERT_IMP(a_data_left, st_ff.stage == ST_DATA, st_ff.chunk_left != '0, "data stage with no bytes left")
   `CBD_ASSERT_NXT(a_rsp_stall, rsp_valid_ff && !rsp_chan.ready, rsp_valid_ff && $stable(st_ff) && $stable(rsp_ff), "result or state moved during a stall")

endmodule

FILE: bench/chunked_body_decoder_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body decoder checker
// Watches the byte and result channels and the register port, keeps its own
// copy of the decoder state and raw byte limit, predicts one result per byte
// transfer and compares every result transfer, in order, field by field.
// ----------------------------------------------------------------------------
module chunked_body_decoder_check import cbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cbd_req_if                    req_chan,
   cbd_rsp_if                    rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    pending
);

   state_type        dec;
   logic [RAW_W-1:0] raw_limit;
   result_type       expected_results[$];

   // {is_hex, value}
   function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] folded;
      folded = c | 8'h20;
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (folded >= "a" && folded <= "f") return {1'b1, 4'(folded - "a" + 8'd10)};
      return 5'b0;
   endfunction

   function automatic void close_size_line();
      dec.saw_cr        = 1'b0;
      dec.line_has_text = 1'b0;
      if (dec.size_accum == '0) begin
         dec.stage = ST_TRAIL;
      end else begin
         dec.chunk_left = dec.size_accum;
         dec.stage      = ST_DATA;
      end
      dec.size_accum  = '0;
      dec.digit_count = '0;
   endfunction

   function automatic result_type decode_byte(input logic [BYTE_W-1:0] c, input logic closed);
      result_type r;
      logic [4:0] nib;
      r.body_valid = 1'b0;
      r.body_byte  = '0;
      r.done_res   = 1'b0;
      nib = hex_nibble(c);
      if (dec.sticky_error == ERR_NONE) begin
         if (closed) begin
            dec.sticky_error = ERR_CLOSED;
         end else begin
            if (dec.raw_count != '1) dec.raw_count = dec.raw_count + 1'b1;
            case (dec.stage)
               ST_SIZE: begin
                  if (dec.saw_cr) begin
                     if (c == CHAR_LF) close_size_line();
                     else dec.sticky_error = ERR_SIZE;
                  end else if (nib[4]) begin
                     if (int'(dec.digit_count) >= MAX_HEX_DIGITS) begin
                        dec.sticky_error = ERR_SIZE;
                     end else begin
                        dec.digit_count = dec.digit_count + 1'b1;
                        dec.size_accum  = {dec.size_accum[SIZE_W-5:0], nib[3:0]};
                     end
                  end else if (dec.digit_count == '0) begin
                     dec.sticky_error = ERR_SIZE;
                  end else if (c == CHAR_CR) begin
                     dec.saw_cr = 1'b1;
                  end else if (c == CHAR_SEMI || c == CHAR_SPACE || c == CHAR_TAB) begin
                     dec.stage = ST_EXT;
                  end else begin
                     dec.sticky_error = ERR_SIZE;
                  end
               end
               ST_EXT: begin
                  if (dec.saw_cr && c == CHAR_LF) close_size_line();
                  else dec.saw_cr = (c == CHAR_CR);
               end
               ST_DATA: begin
                  dec.chunk_left = dec.chunk_left - 1'b1;
                  if (dec.chunk_left != '0 && dec.raw_count >= raw_limit) begin
                     dec.sticky_error = ERR_LIMIT;
                  end else begin
                     r.body_valid = 1'b1;
                     r.body_byte  = c;
                     if (dec.chunk_left == '0) begin
                        dec.stage  = ST_CRLF;
                        dec.saw_cr = 1'b0;
                     end
                  end
               end
               ST_CRLF: begin
                  if (!dec.saw_cr) begin
                     if (c == CHAR_CR) dec.saw_cr = 1'b1;
                     else dec.sticky_error = ERR_CRLF;
                  end else if (c == CHAR_LF) begin
                     dec.stage       = ST_SIZE;
                     dec.saw_cr      = 1'b0;
                     dec.size_accum  = '0;
                     dec.digit_count = '0;
                  end else begin
                     dec.sticky_error = ERR_CRLF;
                  end
               end
               default: begin
                  if (dec.saw_cr && c == CHAR_LF) begin
                     if (!dec.line_has_text) begin
                        // blank line ends the body; start over for the next one
                        r.done_res = 1'b1;
                        dec = STATE_RESET;
                     end else begin
                        dec.line_has_text = 1'b0;
                        dec.saw_cr        = 1'b0;
                     end
                  end else begin
                     if (dec.saw_cr) dec.line_has_text = 1'b1;
                     if (c == CHAR_CR) begin
                        dec.saw_cr = 1'b1;
                     end else begin
                        dec.line_has_text = 1'b1;
                        dec.saw_cr        = 1'b0;
                     end
                  end
               end
            endcase
         end
      end
      r.status = dec.sticky_error;
      return r;
   endfunction

   function automatic void compare_field(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         dec        = STATE_RESET;
         raw_limit  = MAX_RAW_RESET;
         expected_results.delete();
         mismatches = 0;
         pending    = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1] == CSR_IDX_MAX_RAW) begin
            raw_limit = csr_pwdata;
         end
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(decode_byte(req_chan.in_byte, req_chan.conn_closed));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result transfer, expected none, actual %0b/%0h/%0b/%0d",
                        $time, rsp_chan.body_valid, rsp_chan.body_byte, rsp_chan.done_res,
                        rsp_chan.status);
            end else begin
               want = expected_results.pop_front();
               compare_field("body_valid", 8'(want.body_valid), 8'(rsp_chan.body_valid));
               compare_field("body_byte", want.body_byte, rsp_chan.body_byte);
               compare_field("done_res", 8'(want.done_res), 8'(rsp_chan.done_res));
               compare_field("status", 8'(want.status), 8'(rsp_chan.status));
            end
         end
         pending = expected_results.size();
      end
   end

endmodule

FILE: bench/chunked_body_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body decoder testbench
// Feeds a short directed body, then random well-formed chunked bodies under
// several raw byte limits (reset value, maximum, one, a mid value), and ends
// with one randomly chosen sticky error followed by ignored noise. Both
// channels stall at random; the checker instance predicts and compares.
// ----------------------------------------------------------------------------
module chunked_body_decoder_test;
   import cbd_pkg::*;

   typedef enum int {
      FAULT_DIGIT_OVERFLOW,
      FAULT_NO_DIGITS,
      FAULT_BAD_SIZE_CHAR,
      FAULT_LONE_SIZE_CR,
      FAULT_MISSING_CRLF,
      FAULT_RAW_LIMIT,
      FAULT_CONN_CLOSE
   } fault_kind;

   localparam logic [CSR_ADDR_W-1:0] MAX_RAW_ADDR = {CSR_IDX_MAX_RAW, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatches, pending;
   int                    sent = 0;
   int                    ready_hold = 0;
   bit                    steady = 1'b0;
   logic [BYTE_W-1:0]     raw_q[$];

   cbd_req_if req_chan();
   cbd_rsp_if rsp_chan();

   chunked_body_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   chunked_body_decoder_check body_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   always #10 clock = ~clock;

   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // result side backpressure
   always @(negedge clock) begin
      if (steady) begin
         rsp_chan.ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold--;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 8) begin
         ready_hold = $urandom_range(0, 1);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // entered and left at a falling edge
   task automatic send_item(input logic [BYTE_W-1:0] b, input logic closed);
      if (!steady && $urandom_range(0, 99) < 8) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.in_byte     <= b;
      req_chan.conn_closed <= closed;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_queued();
      while (raw_q.size() > 0) send_item(raw_q.pop_front(), 1'b0);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_max_raw(input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAX_RAW_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return "0" + 8'(v);
      return ($urandom_range(0, 1) ? "A" : "a") + 8'(v) - 8'd10;
   endfunction

   // any byte, but never LF right after CR
   function automatic logic [BYTE_W-1:0] text_byte(input logic [BYTE_W-1:0] prev);
      logic [BYTE_W-1:0] b;
      b = 8'($urandom_range(0, 255));
      if (prev == CHAR_CR && b == CHAR_LF) b = "x";
      return b;
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) raw_q.push_back(s[i]);
   endtask

   task automatic push_crlf();
      raw_q.push_back(CHAR_CR);
      raw_q.push_back(CHAR_LF);
   endtask

   task automatic push_size_line(input logic [SIZE_W-1:0] size);
      int n;
      int width;
      logic [BYTE_W-1:0] prev;
      n = 1;
      while (n < MAX_HEX_DIGITS && (size >> (4 * n)) != '0) n++;
      width = n;
      // pad with leading zeros now and then, up to the full digit budget
      if ($urandom_range(0, 5) == 0) width = $urandom_range(n, MAX_HEX_DIGITS);
      for (int i = width - 1; i >= 0; i--) raw_q.push_back(hex_char(size[4 * i +: 4]));
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 2))
            0:       prev = CHAR_SEMI;
            1:       prev = CHAR_SPACE;
            default: prev = CHAR_TAB;
         endcase
         raw_q.push_back(prev);
         repeat ($urandom_range(0, 5)) begin
            prev = text_byte(prev);
            raw_q.push_back(prev);
         end
      end
      push_crlf();
   endtask

   task automatic push_body(input int max_size, input int max_chunks);
      int s;
      logic [BYTE_W-1:0] prev;
      repeat ($urandom_range(0, max_chunks)) begin
         s = $urandom_range(1, max_size);
         push_size_line(SIZE_W'(s));
         repeat (s) raw_q.push_back(8'($urandom_range(0, 255)));
         push_crlf();
      end
      push_size_line('0);
      repeat ($urandom_range(0, 2)) begin
         prev = 8'($urandom_range(0, 255));
         raw_q.push_back(prev);
         repeat ($urandom_range(0, 6)) begin
            prev = text_byte(prev);
            raw_q.push_back(prev);
         end
         push_crlf();
      end
      push_crlf();
   endtask

   initial begin
      fault_kind fault;
      int cut;
      req_chan.valid       = 1'b0;
      req_chan.in_byte     = '0;
      req_chan.conn_closed = 1'b0;
      rsp_chan.ready       = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extension with CR inside, extreme data bytes, trailer with a lone CR
      push_text("1;");
      raw_q.push_back(CHAR_CR);
      push_crlf();
      raw_q.push_back(8'hFF);
      push_crlf();
      push_text("1");
      push_crlf();
      raw_q.push_back(8'h00);
      push_crlf();
      push_text("0");
      push_crlf();
      push_text("T");
      raw_q.push_back(CHAR_CR);
      push_crlf();
      push_crlf();
      send_queued();

      while (sent < 200) begin
         push_body(16, 4);
         send_queued();
      end

      drain();
      write_max_raw('1);
      while (sent < 380) begin
         push_body(($urandom_range(0, 9) == 0) ? 300 : 16, 4);
         send_queued();
      end

      // a limit of one still lets single-byte chunks through
      drain();
      write_max_raw(32'd1);
      while (sent < 480) begin
         push_body(1, 4);
         send_queued();
      end

      drain();
      write_max_raw(32'($urandom_range(300, 5000)));
      steady = 1'b1;
      while (sent < 650) begin
         push_body(16, 4);
         send_queued();
      end
      steady = 1'b0;

      // end on one sticky error, then check that later input is ignored
      drain();
      fault = fault_kind'($urandom_range(0, 6));
      case (fault)
         FAULT_DIGIT_OVERFLOW: begin
            repeat (MAX_HEX_DIGITS + 1) raw_q.push_back(hex_char(4'($urandom_range(0, 15))));
         end
         FAULT_NO_DIGITS: begin
            raw_q.push_back($urandom_range(0, 1) ? CHAR_CR : 8'($urandom_range(8'h80, 8'hFF)));
         end
         FAULT_BAD_SIZE_CHAR: begin
            push_text("2");
            raw_q.push_back($urandom_range(0, 1) ? CHAR_LF : 8'($urandom_range(8'h80, 8'hFF)));
         end
         FAULT_LONE_SIZE_CR: begin
            push_text("5");
            raw_q.push_back(CHAR_CR);
            raw_q.push_back(text_byte(CHAR_CR));
         end
         FAULT_MISSING_CRLF: begin
            push_size_line(SIZE_W'(2));
            repeat (2) raw_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) begin
               raw_q.push_back(8'($urandom_range(0, 8'h0C)));
            end else begin
               raw_q.push_back(CHAR_CR);
               raw_q.push_back(text_byte(CHAR_CR));
            end
         end
         FAULT_RAW_LIMIT: begin
            write_max_raw(32'($urandom_range(1, 40)));
            repeat (MAX_HEX_DIGITS) raw_q.push_back(hex_char(4'hF));
            push_crlf();
            repeat (40) raw_q.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            push_body(16, 3);
            cut = $urandom_range(0, raw_q.size() - 1);
            while (raw_q.size() > cut) void'(raw_q.pop_back());
         end
      endcase
      send_queued();
      if (fault == FAULT_CONN_CLOSE) send_item(8'($urandom_range(0, 255)), 1'b1);
      repeat (20) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/cbd_pkg.sv
hdl/cbd_req_if.sv
hdl/cbd_rsp_if.sv
hdl/cbd_csr.sv
hdl/cbd_step.sv
hdl/chunked_body_decoder.sv
bench/chunked_body_decoder_check.sv
bench/chunked_body_decoder_test.sv
